[hw/rtl/b64d_pkg.sv]
// Shared types, constants and the alphabet lookup for the base64url decoder.
// No dependencies; imported by every module of the decoder.
package b64d_pkg;

    // Limit on the decoded byte count; the count field itself is 16 bits wide.
    localparam int unsigned MAX_OUT_BYTES = 65535;
    localparam int unsigned COUNT_W       = 16;
    localparam int unsigned COUNT_FIELD_MAX = 65535;
    localparam logic [COUNT_W-1:0] COUNT_LIMIT =
        (MAX_OUT_BYTES > COUNT_FIELD_MAX) ? COUNT_W'(COUNT_FIELD_MAX)
                                          : COUNT_W'(MAX_OUT_BYTES);

    // Queue between front and back.
    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_AW    = $clog2(Q_DEPTH);
    localparam int unsigned Q_CW    = $clog2(Q_DEPTH + 1);

    // Special characters.
    localparam logic [7:0] PAD_CHAR = 8'h3D;
    localparam logic [7:0] NUL_CHAR = 8'h00;

    // Position of a character within its group of four.
    localparam logic [1:0] POS_FIRST  = 2'd0;
    localparam logic [1:0] POS_SECOND = 2'd1;
    localparam logic [1:0] POS_THIRD  = 2'd2;
    localparam logic [1:0] POS_FOURTH = 2'd3;

    // Classified character, as passed from front to back.
    typedef struct packed {
        logic [5:0] sextet;
        logic       is_nul;
        logic       is_pad;
        logic       last;
    } t_cls;

    // base64url alphabet: A-Z, a-z, 0-9, '-', '_'; anything else is zero.
    function automatic logic [5:0] sextet_of(input logic [7:0] c);
        logic [7:0] v;
        begin
            v = 8'd0;
            if (c inside {[8'h41:8'h5A]}) begin
                v = c - 8'h41;
            end else if (c inside {[8'h61:8'h7A]}) begin
                v = c - 8'h61 + 8'd26;
            end else if (c inside {[8'h30:8'h39]}) begin
                v = c - 8'h30 + 8'd52;
            end else if (c == 8'h2D) begin
                v = 8'd62;
            end else if (c == 8'h5F) begin
                v = 8'd63;
            end
            return v[5:0];
        end
    endfunction

endpackage

[hw/rtl/b64d_front.sv]
// Front end: accepts text characters and classifies them for the back end.
// Depends on b64d_pkg (t_cls, sextet_of, special characters).
module b64d_front (
    input  logic              i_push,
    input  logic [7:0]        i_char_in,
    input  logic              i_last_char,
    input  logic              i_q_full,
    output logic              o_full,
    output logic              o_wr_en,
    output b64d_pkg::t_cls    o_item
);
    import b64d_pkg::*;

    assign o_full  = i_q_full;
    assign o_wr_en = i_push && !i_q_full;

    always_comb begin
        o_item.sextet = sextet_of(i_char_in);
        o_item.is_nul = (i_char_in == NUL_CHAR);
        o_item.is_pad = (i_char_in == PAD_CHAR);
        o_item.last   = i_last_char;
    end

endmodule

[hw/rtl/b64d_queue.sv]
// Short FIFO of classified items between front and back end.
// Depends on b64d_pkg (t_cls, queue sizes).
module b64d_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr_en,
    input  b64d_pkg::t_cls    i_item,
    input  logic              i_rd_en,
    output b64d_pkg::t_cls    o_item,
    output logic              o_full,
    output logic              o_empty
);
    import b64d_pkg::*;

    t_cls            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr;
    logic [Q_CW-1:0] r_count;
    logic            wr;
    logic            rd;

    assign o_full  = (r_count == Q_CW'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign wr      = i_wr_en && !o_full;
    assign rd      = i_rd_en && !o_empty;
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (wr && !rd) begin
                r_count <= r_count + 1'b1;
            end else if (rd && !wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Q_CW'(Q_DEPTH))
        else $error("queue count beyond depth");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_ptr != r_rd_ptr) |-> (!o_empty && !o_full))
        else $error("queue pointers disagree with count");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr && !rd) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count missed a write");

endmodule

[hw/rtl/b64d_back.sv]
// Back end: group state, byte assembly, saturating count and result register.
// Depends on b64d_pkg (t_cls, positions, count limit).
module b64d_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_empty,
    input  b64d_pkg::t_cls              i_item,
    output logic                        o_q_pop,
    input  logic                        i_pop,
    output logic                        o_empty,
    output logic                        o_has_byte,
    output logic [7:0]                  o_data_byte,
    output logic                        o_end_of_string,
    output logic [b64d_pkg::COUNT_W-1:0] o_byte_count
);
    import b64d_pkg::*;

    logic [1:0]         r_pos;
    logic [5:0]         r_prev;
    logic               r_halted;
    logic               r_ended;
    logic [COUNT_W-1:0] r_count;
    logic               r_out_valid;
    logic               r_has;
    logic [7:0]         r_byte;
    logic               r_eos;
    logic [COUNT_W-1:0] r_out_count;

    logic [1:0]         n_pos;
    logic [5:0]         n_prev;
    logic               n_halted;
    logic               n_ended;
    logic [COUNT_W-1:0] n_count;
    logic               emit;
    logic [7:0]         byte_val;
    logic [COUNT_W-1:0] count_step;
    logic               take;

    // Output register frees up when empty or being popped.
    assign take    = !i_q_empty && (!r_out_valid || i_pop);
    assign o_q_pop = take;

    always_comb begin
        emit     = 1'b0;
        byte_val = 8'd0;
        n_prev   = r_prev;
        n_halted = r_halted;
        n_ended  = r_ended;
        if (!r_ended) begin
            if (i_item.is_nul) begin
                n_ended = 1'b1;
            end else if (!r_halted) begin
                if (i_item.is_pad) begin
                    n_halted = 1'b1;
                end else begin
                    case (r_pos)
                        POS_SECOND: begin
                            byte_val = {r_prev, i_item.sextet[5:4]};
                            emit     = 1'b1;
                        end
                        POS_THIRD: begin
                            byte_val = {r_prev[3:0], i_item.sextet[5:2]};
                            emit     = 1'b1;
                        end
                        POS_FOURTH: begin
                            byte_val = {r_prev[1:0], i_item.sextet};
                            emit     = 1'b1;
                        end
                        default: begin
                            byte_val = 8'd0;
                        end
                    endcase
                    n_prev = i_item.sextet;
                end
            end
        end

        count_step = (emit && (r_count < COUNT_LIMIT)) ? r_count + 1'b1 : r_count;

        if (r_pos == POS_FOURTH) begin
            n_pos    = POS_FIRST;
            n_halted = 1'b0;
            n_prev   = 6'd0;
        end else begin
            n_pos = r_pos + 1'b1;
        end
        n_count = count_step;

        // Last character: state back to reset after its result is formed.
        if (i_item.last) begin
            n_pos    = POS_FIRST;
            n_prev   = 6'd0;
            n_halted = 1'b0;
            n_ended  = 1'b0;
            n_count  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= POS_FIRST;
            r_prev      <= 6'd0;
            r_halted    <= 1'b0;
            r_ended     <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_pos    <= n_pos;
                r_prev   <= n_prev;
                r_halted <= n_halted;
                r_ended  <= n_ended;
                r_count  <= n_count;
            end
            if (take) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_has       <= emit;
            r_byte      <= byte_val;
            r_eos       <= i_item.last;
            r_out_count <= count_step;
        end
    end

    assign o_empty         = !r_out_valid;
    assign o_has_byte      = r_has;
    assign o_data_byte     = r_byte;
    assign o_end_of_string = r_eos;
    assign o_byte_count    = r_out_count;

    a_group_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos == POS_FIRST) |-> (r_prev == 6'd0 && !r_halted))
        else $error("group start with stale sextet or halt flag");

    a_no_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_has) |-> (r_byte == 8'd0))
        else $error("byte value present without a byte");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_item.last) |=> (r_pos == POS_FIRST && !r_ended && r_count == '0))
        else $error("state not cleared after last character");

endmodule

[hw/rtl/base64url_stream_decoder.sv]
// Streaming base64url decoder, one text character in and one result out per item.
// Accepted characters are written into the queue; the back end moves each into the result
// register when that register is free, and the consumer pops it from there.
// Throughput: 1 item per cycle while the consumer keeps popping, set by the back-end loop.
// A 4-entry queue separates front and back so either side may stall on its own.
// Reset: synchronous, active low; clears queue, group state and output valid.
module base64url_stream_decoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input side: queue-like push/full
    input  logic                          i_push,
    output logic                          o_full,
    input  logic [7:0]                    i_char_in,
    input  logic                          i_last_char,
    // result side: queue-like empty/pop
    output logic                          o_empty,
    input  logic                          i_pop,
    output logic                          o_has_byte,
    output logic [7:0]                    o_data_byte,
    output logic                          o_end_of_string,
    output logic [b64d_pkg::COUNT_W-1:0]  o_byte_count
);
    import b64d_pkg::*;

    // Classified item from the front, written straight into the queue.
    t_cls front_item;
    t_cls queue_item;
    logic front_wr;
    logic q_full;
    logic q_empty;
    logic q_pop;

    // Front: alphabet lookup plus NUL / pad detection, no state of its own.
    b64d_front u_front (
        .i_push      (i_push),
        .i_char_in   (i_char_in),
        .i_last_char (i_last_char),
        .i_q_full    (q_full),
        .o_full      (o_full),
        .o_wr_en     (front_wr),
        .o_item      (front_item)
    );

    // Decoupling queue; full here back-pressures the input side.
    b64d_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (front_wr),
        .i_item  (front_item),
        .i_rd_en (q_pop),
        .o_item  (queue_item),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // Back: group position, previous sextet, pad/NUL flags, saturating count,
    // and the result register that the consumer pops from.
    b64d_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_empty       (q_empty),
        .i_item          (queue_item),
        .o_q_pop         (q_pop),
        .i_pop           (i_pop),
        .o_empty         (o_empty),
        .o_has_byte      (o_has_byte),
        .o_data_byte     (o_data_byte),
        .o_end_of_string (o_end_of_string),
        .o_byte_count    (o_byte_count)
    );

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for base64url_stream_decoder: directed, random and long-string stimulus.
// Depends on b64d_pkg for the count width, the count limit and the special character codes.
`timescale 1ns / 100ps

typedef struct packed {
    logic                        has_byte;
    logic [7:0]                  data_byte;
    logic                        end_of_string;
    logic [b64d_pkg::COUNT_W-1:0] byte_count;
} t_decoded;

// Tracks the decoder state and holds the decoded results still to come out
class b64_decode_tracker;
    t_decoded    pending_decodes[$];
    logic [1:0]  grp_pos;
    logic [5:0]  prev_val;
    bit          halted;
    bit          ended;
    logic [b64d_pkg::COUNT_W-1:0] out_count;
    int unsigned mismatches;
    int unsigned bytes_seen;
    bit          saturated;

    function new();
        clear_state();
        mismatches = 0;
        bytes_seen = 0;
        saturated  = 0;
    endfunction

    function void clear_state();
        grp_pos   = b64d_pkg::POS_FIRST;
        prev_val  = '0;
        halted    = 0;
        ended     = 0;
        out_count = '0;
    endfunction

    function int pending();
        return pending_decodes.size();
    endfunction

    // Accepted character: decode it and queue what the block should return
    function void note_char(input logic [7:0] c, input logic last);
        t_decoded   r;
        logic [5:0] v;
        logic [7:0] b;
        logic       emit;
        emit = 0;
        b    = '0;
        v    = '0;
        if (!ended) begin
            if (c == b64d_pkg::NUL_CHAR) begin
                ended = 1;
            end else if (!halted) begin
                if (c == b64d_pkg::PAD_CHAR) begin
                    halted = 1;
                end else begin
                    if (c >= "A" && c <= "Z") v = 6'(c - "A");
                    else if (c >= "a" && c <= "z") v = 6'(c - "a" + 26);
                    else if (c >= "0" && c <= "9") v = 6'(c - "0" + 52);
                    else if (c == "-") v = 6'd62;
                    else if (c == "_") v = 6'd63;
                    case (grp_pos)
                        b64d_pkg::POS_SECOND: begin
                            b = {prev_val, v[5:4]};
                            emit = 1;
                        end
                        b64d_pkg::POS_THIRD: begin
                            b = {prev_val[3:0], v[5:2]};
                            emit = 1;
                        end
                        b64d_pkg::POS_FOURTH: begin
                            b = {prev_val[1:0], v};
                            emit = 1;
                        end
                        default: ;
                    endcase
                    prev_val = v;
                end
            end
        end
        if (emit && out_count < b64d_pkg::COUNT_LIMIT) out_count++;
        r.has_byte      = emit;
        r.data_byte     = b;
        r.end_of_string = last;
        r.byte_count    = out_count;
        pending_decodes.push_back(r);
        if (grp_pos == b64d_pkg::POS_FOURTH) begin
            grp_pos  = b64d_pkg::POS_FIRST;
            halted   = 0;
            prev_val = '0;
        end else begin
            grp_pos = grp_pos + 2'd1;
        end
        if (last) clear_state();
    endfunction

    function void check_result(input t_decoded got);
        t_decoded want;
        if (pending_decodes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] unexpected result: has=%0b byte=%02h eos=%0b cnt=%0d",
                         $realtime, got.has_byte, got.data_byte, got.end_of_string,
                         got.byte_count);
            return;
        end
        want = pending_decodes.pop_front();
        if (got.has_byte === 1'b1) bytes_seen++;
        if (got.byte_count === b64d_pkg::COUNT_LIMIT) saturated = 1;
        if (got.has_byte !== want.has_byte || got.data_byte !== want.data_byte ||
            got.end_of_string !== want.end_of_string || got.byte_count !== want.byte_count)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] exp has/byte/eos/cnt=%0b/%02h/%0b/%0d, got %0b/%02h/%0b/%0d",
                         $realtime, want.has_byte, want.data_byte, want.end_of_string,
                         want.byte_count, got.has_byte, got.data_byte, got.end_of_string,
                         got.byte_count);
        end
    endfunction
endclass

module testbench;
    import b64d_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int unsigned RANDOM_CHARS = 1050;
    // One unbroken string over many groups, with no end flag until the very end
    localparam int unsigned LONG_CHARS   = 120;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_push = 1'b0;
    logic [7:0]         i_char_in = 8'h00;
    logic               i_last_char = 1'b0;
    logic               i_pop = 1'b0;
    logic               o_full;
    logic               o_empty;
    logic               o_has_byte;
    logic [7:0]         o_data_byte;
    logic               o_end_of_string;
    logic [COUNT_W-1:0] o_byte_count;

    b64_decode_tracker  tracker;
    t_decoded           seen;
    string              b64_alphabet =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";
    bit                 quiet = 0;      // no idling on either side while set
    int unsigned        chars_sent = 0;
    int unsigned        strings_sent = 0;
    int unsigned        cycle_count = 0;

    base64url_stream_decoder u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (i_push),
        .o_full          (o_full),
        .i_char_in       (i_char_in),
        .i_last_char     (i_last_char),
        .o_empty         (o_empty),
        .i_pop           (i_pop),
        .o_has_byte      (o_has_byte),
        .o_data_byte     (o_data_byte),
        .o_end_of_string (o_end_of_string),
        .o_byte_count    (o_byte_count)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    // Watchdog: a hung handshake ends the run here
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("base64url_stream_decoder: mismatch");
        $finish;
    end

    // Result side: outputs are read at the edge (pre-update values), so an item
    // counts as taken exactly when pop and not-empty held in the cycle before.
    always @(posedge i_clk) begin
        if (i_rst_n && i_pop && !o_empty) begin
            seen.has_byte      = o_has_byte;
            seen.data_byte     = o_data_byte;
            seen.end_of_string = o_end_of_string;
            seen.byte_count    = o_byte_count;
            tracker.check_result(seen);
        end
        // stall roughly 28% of cycles, never during a quiet stretch
        i_pop <= quiet || ($urandom_range(0, 99) >= 28);
    end

    function automatic logic [7:0] alpha_char();
        return b64_alphabet[$urandom_range(0, 63)];
    endfunction

    // Offer one character and hold it until the block takes it.
    // Push is only lowered when a gap is inserted, so it never toggles within a step.
    task automatic send_char(input logic [7:0] c, input logic last);
        int unsigned gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 99) < 26) gap = $urandom_range(1, 2);
        if (gap != 0) begin
            i_push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_push      <= 1'b1;
        i_char_in   <= c;
        i_last_char <= last;
        do @(posedge i_clk); while (o_full);
        tracker.note_char(c, last);
        chars_sent++;
    endtask

    // Whole string, with the end flag on its final character
    task automatic send_text(input logic [7:0] t[$]);
        for (int i = 0; i < t.size(); i++)
            send_char(t[i], i == t.size() - 1);
        strings_sent++;
    endtask

    initial begin
        logic [7:0]  text[$];
        int unsigned rand_start;
        int unsigned kind;
        int unsigned n;
        int unsigned k;

        tracker = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed part ---
        // top of alphabet, out-of-alphabet bytes, pad mid-group, NUL in a skipped
        // remainder, then two characters after the NUL, the last closing the string
        text = '{"_", "-", "_", "9", 8'hFF, "+", 8'h80, "A", "z", PAD_CHAR, NUL_CHAR,
                 "Q", "Q"};
        send_text(text);
        // string ending part way through a group
        text = '{"Z", "m", "9"};
        send_text(text);
        // NUL on the fourth position, trailing character must give nothing
        text = '{"T", "W", "F", NUL_CHAR, "u"};
        send_text(text);
        text = '{PAD_CHAR};
        send_text(text);
        text = '{NUL_CHAR};
        send_text(text);
        text = '{"A", "A"};
        send_text(text);

        // hold the sender until the block has drained completely
        i_push <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);

        // --- random part ---
        // mostly well-formed strings; some broken by a stray byte, some pure noise
        rand_start = chars_sent;
        while (chars_sent - rand_start < RANDOM_CHARS) begin
            n     = chars_sent - rand_start;
            quiet = (n >= 400 && n < 700);
            text.delete();
            kind = $urandom_range(0, 99);
            if (kind < 85) begin
                repeat ($urandom_range(1, 6))
                    repeat (4) text.push_back(alpha_char());
                case ($urandom_range(0, 3))
                    1: begin
                        text[text.size() - 1] = PAD_CHAR;
                        text[text.size() - 2] = PAD_CHAR;
                    end
                    2: text[text.size() - 1] = PAD_CHAR;
                    3: repeat ($urandom_range(1, 3)) void'(text.pop_back());
                    default: ;
                endcase
                if (kind >= 70) begin
                    k = $urandom_range(0, text.size() - 1);
                    case ($urandom_range(0, 2))
                        0: text[k] = NUL_CHAR;
                        1: text[k] = PAD_CHAR;
                        default: text[k] = 8'($urandom_range(0, 255));
                    endcase
                end
            end else begin
                repeat ($urandom_range(1, 12)) begin
                    case ($urandom_range(0, 9))
                        0: text.push_back(NUL_CHAR);
                        1: text.push_back(PAD_CHAR);
                        default: text.push_back(8'($urandom_range(0, 255)));
                    endcase
                end
            end
            send_text(text);
        end
        quiet = 0;

        // --- one long string, the count keeps climbing across many groups ---
        for (k = 0; k < LONG_CHARS; k++) send_char(alpha_char(), 1'b0);
        send_char("Q", 1'b0);
        send_char("x", 1'b1);
        strings_sent++;

        // --- drain ---
        i_push <= 1'b0;
        for (k = 0; k < 4000 && tracker.pending() != 0; k++) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (tracker.pending() != 0) begin
            $display("%0d decoded results never came out", tracker.pending());
            tracker.mismatches++;
        end

        $display("Ran %0d strings (%0d characters): alphabet, padding, NUL and junk bytes.",
                 strings_sent, chars_sent);
        $display("%0d decoded bytes seen; byte count reached its limit: %0s",
                 tracker.bytes_seen, tracker.saturated ? "yes" : "no");
        if (tracker.mismatches == 0)
            $display("base64url_stream_decoder: match");
        else
            $display("base64url_stream_decoder: mismatch");
        $finish;
    end

endmodule
